@@ hw/rtl/hcic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcic_pkg
// Shared constants for the Hilbert curve index converter: port widths,
// register width and reset value, and the direction codes of an item.
// ----------------------------------------------------------------------------
package hcic_pkg;

    // fixed port widths
    localparam int COORD_W = 16;
    localparam int INDEX_W = 32;
    localparam int ORDER_W = 5;

    // default number of levels built in hardware
    localparam int MAX_ORDER_DEF = 16;

    // curve order after reset
    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd6;

    // direction codes
    localparam logic ACT_XY2D = 1'b0;
    localparam logic ACT_D2XY = 1'b1;

endpackage : hcic_pkg
`default_nettype wire

@@ hw/rtl/hilbert_curve_index_conversion.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hilbert_curve_index_conversion
// Converts grid coordinates to Hilbert curve distance and back, one level
// per cell in a chain of MAX_ORDER cells.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     action, in_x, in_y, in_index
//   output    out_valid / out_stall   out_index, out_x, out_y
//   config    cfg_valid / cfg_ready   cfg_data (curve order)
//
// One item per cycle sustained while the output is not stalled; each item
// passes through the chain of level cells, after any wait in the input skid
// stage.
// The chain moves as a whole when its last stage is empty or not stalled.
// in_stall comes from the registered skid stage only.
// Reset clears all valid bits and sets the curve order to 6.
// ----------------------------------------------------------------------------
module hilbert_curve_index_conversion #(
    parameter int MAX_ORDER = hcic_pkg::MAX_ORDER_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [hcic_pkg::COORD_W-1:0]  in_x,
    input  wire logic [hcic_pkg::COORD_W-1:0]  in_y,
    input  wire logic [hcic_pkg::INDEX_W-1:0]  in_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hcic_pkg::INDEX_W-1:0]       out_index,
    output logic [hcic_pkg::COORD_W-1:0]       out_x,
    output logic [hcic_pkg::COORD_W-1:0]       out_y,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hcic_pkg::ORDER_W-1:0]  cfg_data
);
    import hcic_pkg::*;

    localparam int W  = MAX_ORDER;
    localparam int DW = 2 * MAX_ORDER;

    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] ord;

    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 skid_act_reg;
    logic [COORD_W-1:0]   skid_x_reg;
    logic [COORD_W-1:0]   skid_y_reg;
    logic [INDEX_W-1:0]   skid_index_reg;

    logic                 advance;
    logic                 src_act;
    logic [COORD_W-1:0]   src_x;
    logic [COORD_W-1:0]   src_y;
    logic [INDEX_W-1:0]   src_index;

    logic [W-1:0]         cmask;
    logic [DW-1:0]        dmask;
    logic [W+COORD_W-1:0] x_ext;
    logic [W+COORD_W-1:0] y_ext;
    logic [DW+INDEX_W-1:0] d_ext;

    // chain stages: entry 0 feeds the first cell
    logic          valid_s [0:MAX_ORDER];
    logic          act_s   [0:MAX_ORDER];
    logic [W-1:0]  wx_s    [0:MAX_ORDER];
    logic [W-1:0]  wy_s    [0:MAX_ORDER];
    logic [W-1:0]  ex_s    [0:MAX_ORDER];
    logic [W-1:0]  ey_s    [0:MAX_ORDER];
    logic [DW-1:0] acc_s   [0:MAX_ORDER];

    logic [W-1:0]         x_sel;
    logic [COORD_W+W-1:0] ox_ext;
    logic [COORD_W+W-1:0] oy_ext;
    logic [INDEX_W+DW-1:0] oi_ext;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_reg <= cfg_data;
        end
    end

    // order saturates at the number of cells
    assign ord = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;

    // masks for coordinate and index bits
    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            cmask[j] = (ord > ORDER_W'(j));
        end
        for (int j = 0; j < DW; j++)
        begin
            dmask[j] = (ord > ORDER_W'(j / 2));
        end
    end

    // chain moves when its last stage can drain
    assign advance = !valid_s[MAX_ORDER] || !out_stall;

    // input skid stage
    assign in_stall = skid_valid_reg;
    assign skid_valid_next = skid_valid_reg ? !advance : (in_valid && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && in_valid && !advance)
        begin
            skid_act_reg   <= action;
            skid_x_reg     <= in_x;
            skid_y_reg     <= in_y;
            skid_index_reg <= in_index;
        end
    end

    // chain entry: skid stage first, then the input port
    assign src_act   = skid_valid_reg ? skid_act_reg   : action;
    assign src_x     = skid_valid_reg ? skid_x_reg     : in_x;
    assign src_y     = skid_valid_reg ? skid_y_reg     : in_y;
    assign src_index = skid_valid_reg ? skid_index_reg : in_index;

    assign x_ext = {{W{1'b0}}, src_x};
    assign y_ext = {{W{1'b0}}, src_y};
    assign d_ext = {{DW{1'b0}}, src_index};

    assign valid_s[0] = skid_valid_reg || in_valid;
    assign act_s[0]   = src_act;
    assign wx_s[0]    = x_ext[W-1:0] & cmask;
    assign wy_s[0]    = y_ext[W-1:0] & cmask;
    assign ex_s[0]    = x_ext[W-1:0] & cmask;
    assign ey_s[0]    = y_ext[W-1:0] & cmask;
    assign acc_s[0]   = (src_act == ACT_D2XY) ? (d_ext[DW-1:0] & dmask) : {DW{1'b0}};

    // one cell per curve level
    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_cell
        hcic_cell #(
            .MAX_ORDER (MAX_ORDER),
            .LEVEL     (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .ord        (ord),
            .prev_valid (valid_s[i]),
            .prev_act   (act_s[i]),
            .prev_wx    (wx_s[i]),
            .prev_wy    (wy_s[i]),
            .prev_ex    (ex_s[i]),
            .prev_ey    (ey_s[i]),
            .prev_acc   (acc_s[i]),
            .valid_reg  (valid_s[i+1]),
            .act_reg    (act_s[i+1]),
            .wx_reg     (wx_s[i+1]),
            .wy_reg     (wy_s[i+1]),
            .ex_reg     (ex_s[i+1]),
            .ey_reg     (ey_s[i+1]),
            .acc_reg    (acc_s[i+1])
        );
    end

    // result item from the last cell
    assign x_sel  = (act_s[MAX_ORDER] == ACT_D2XY) ? wx_s[MAX_ORDER] : ex_s[MAX_ORDER];
    assign ox_ext = {{COORD_W{1'b0}}, x_sel};
    assign oy_ext = {{COORD_W{1'b0}},
                     (act_s[MAX_ORDER] == ACT_D2XY) ? wy_s[MAX_ORDER] : ey_s[MAX_ORDER]};
    assign oi_ext = {{INDEX_W{1'b0}}, acc_s[MAX_ORDER]};

    assign out_valid = valid_s[MAX_ORDER];
    assign out_x     = ox_ext[COORD_W-1:0];
    assign out_y     = oy_ext[COORD_W-1:0];
    assign out_index = oi_ext[INDEX_W-1:0];

endmodule : hilbert_curve_index_conversion
`default_nettype wire

@@ hw/rtl/hcic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcic_cell
// One level of the Hilbert curve. Forward items take the quadrant of bit
// MAX_ORDER-1-LEVEL and reflect or swap the coordinates; reverse items take
// index bits at 2*LEVEL and place the coordinate bits at LEVEL. The result
// is registered and handed to the next cell.
// ----------------------------------------------------------------------------
module hcic_cell #(
    parameter int MAX_ORDER = hcic_pkg::MAX_ORDER_DEF,
    parameter int LEVEL     = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [hcic_pkg::ORDER_W-1:0] ord,
    input  wire logic                         prev_valid,
    input  wire logic                         prev_act,
    input  wire logic [MAX_ORDER-1:0]         prev_wx,
    input  wire logic [MAX_ORDER-1:0]         prev_wy,
    input  wire logic [MAX_ORDER-1:0]         prev_ex,
    input  wire logic [MAX_ORDER-1:0]         prev_ey,
    input  wire logic [2*MAX_ORDER-1:0]       prev_acc,
    output logic                              valid_reg,
    output logic                              act_reg,
    output logic [MAX_ORDER-1:0]              wx_reg,
    output logic [MAX_ORDER-1:0]              wy_reg,
    output logic [MAX_ORDER-1:0]              ex_reg,
    output logic [MAX_ORDER-1:0]              ey_reg,
    output logic [2*MAX_ORDER-1:0]            acc_reg
);
    import hcic_pkg::*;

    // bit position handled going down (forward) and going up (reverse)
    localparam int FWD_BIT = MAX_ORDER - 1 - LEVEL;
    localparam int REV_BIT = LEVEL;
    localparam logic [MAX_ORDER-1:0] LOW_MASK =
        MAX_ORDER'((64'd1 << REV_BIT) - 64'd1);

    logic [MAX_ORDER-1:0]   wx_next;
    logic [MAX_ORDER-1:0]   wy_next;
    logic [2*MAX_ORDER-1:0] acc_next;

    // level step
    always_comb
    begin
        logic rx;
        logic ry;
        logic [MAX_ORDER-1:0] xs;
        logic [MAX_ORDER-1:0] ys;
        wx_next  = prev_wx;
        wy_next  = prev_wy;
        acc_next = prev_acc;
        rx       = 1'b0;
        ry       = 1'b0;
        xs       = prev_wx;
        ys       = prev_wy;
        if (prev_act == ACT_XY2D)
        begin
            if (ord > ORDER_W'(FWD_BIT))
            begin
                rx = prev_wx[FWD_BIT];
                ry = prev_wy[FWD_BIT];
                acc_next[2*FWD_BIT+1 -: 2] = {rx, rx ^ ry};
                if (!ry)
                begin
                    xs      = rx ? ~prev_wx : prev_wx;
                    ys      = rx ? ~prev_wy : prev_wy;
                    wx_next = ys;
                    wy_next = xs;
                end
            end
        end
        else
        begin
            if (ord > ORDER_W'(REV_BIT))
            begin
                rx = prev_acc[2*REV_BIT+1];
                ry = prev_acc[2*REV_BIT] ^ rx;
                if (!ry)
                begin
                    xs      = rx ? (~prev_wx & LOW_MASK) : prev_wx;
                    ys      = rx ? (~prev_wy & LOW_MASK) : prev_wy;
                    wx_next = ys;
                    wy_next = xs;
                end
                wx_next[REV_BIT] = rx;
                wy_next[REV_BIT] = ry;
            end
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act_reg <= prev_act;
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            ex_reg  <= prev_ex;
            ey_reg  <= prev_ey;
            acc_reg <= acc_next;
        end
    end

endmodule : hcic_cell
`default_nettype wire
